// ===== hdl/epsm_pkg.sv =====
package epsm_pkg;

    localparam int DATA_W   = 32;
    localparam int DEB_W    = 16;
    localparam int EPR_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W    = $clog2(DATA_W);

    // 628318 * 4096, speed numerator in q12
    localparam logic [DATA_W-1:0] SPEED_NUM_Q12 = 32'd2573590528;

    localparam logic [DEB_W-1:0]  DEB_RESET   = 16'd20;
    localparam logic [EPR_W-1:0]  EPR_RESET   = 8'd26;
    localparam logic [DATA_W-1:0] STALL_RESET = 32'd200000;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_EPR      = 2'd1,
        CFG_STALL    = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_NONE  = 2'd0,
        STAT_ZERO  = 2'd1,
        STAT_STALL = 2'd2,
        STAT_VALID = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   ticks;
        logic                done;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_WAIT = 2'd2
    } t_bk_state;

endpackage

// ===== hdl/encoder_period_speed_meter_top.sv =====
// channel   direction  handshake               beat contents
// ------    ---------  ----------------------  ---------------------------------------
// tick in   input      push / full             i_edge_seen
// result    output     empty / pop             o_status o_rev_ticks o_speed_q12 o_rev_done
// config    input      i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// a tick beat is taken when not full; the front updates timer, last edge and edge count at once
// a result with valid speed goes through the bit-serial divider, which the back starts, steps
// msb first and then moves the quotient out; other results load directly in the back
// a 4-entry job queue sits between front and back, so ticks keep coming while the divider runs
// one output register holds the oldest result; it is refilled in the cycle it is popped
// reset is synchronous, active low; config registers reload their defaults, no clearing pass
module encoder_period_speed_meter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick input
    input  logic                            push,
    output logic                            full,
    input  logic                            i_edge_seen,
    // results
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_status,
    output logic [epsm_pkg::DATA_W-1:0]     o_rev_ticks,
    output logic [epsm_pkg::DATA_W-1:0]     o_speed_q12,
    output logic                            o_rev_done,
    // config writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [epsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [epsm_pkg::DATA_W-1:0]     i_cfg_data
);
    import epsm_pkg::*;

    // front to queue
    logic q_push;
    t_job front_job;
    logic q_full;

    // queue to back
    t_job q_job;
    logic q_empty;
    logic q_pop;

    // back output register
    t_job              out_job;
    logic [DATA_W-1:0] out_speed;

    // config is always taken, writes land in the front
    assign o_cfg_ready = 1'b1;

    epsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_edge_seen (i_edge_seen),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_job       (front_job)
    );

    // full toward the source is the job queue full
    assign full = q_full;

    epsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    epsm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_job   (q_job),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_job     (out_job),
        .o_speed   (out_speed)
    );

    // result fields straight from the output register
    assign o_status    = out_job.status;
    assign o_rev_ticks = out_job.ticks;
    assign o_speed_q12 = out_speed;
    assign o_rev_done  = out_job.done;

endmodule

// ===== hdl/epsm_front.sv =====
module epsm_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [epsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [epsm_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                              i_push,
    input  logic                              i_edge_seen,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output epsm_pkg::t_job                    o_job
);
    import epsm_pkg::*;

    logic [DEB_W-1:0]  r_debounce;
    logic [EPR_W-1:0]  r_epr;
    logic [DATA_W-1:0] r_stall_limit;

    logic [DATA_W-1:0] r_tick_timer, n_tick_timer;
    logic [DATA_W-1:0] r_last_edge, n_last_edge;
    logic [EPR_W-1:0]  r_edge_cnt, n_edge_cnt;
    logic [DATA_W-1:0] r_rev_time, n_rev_time;
    logic              r_rev_ready, n_rev_ready;

    logic [DATA_W-1:0] gap;
    logic [EPR_W-1:0]  cnt_inc;
    logic              edge_ok;
    logic              rev;
    logic              accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        gap     = r_tick_timer - r_last_edge;
        edge_ok = i_edge_seen && (gap >= {{(DATA_W-DEB_W){1'b0}}, r_debounce});
        cnt_inc = r_edge_cnt + 1'b1;
        rev     = edge_ok && (cnt_inc >= r_epr);

        n_last_edge  = edge_ok ? r_tick_timer : r_last_edge;
        n_edge_cnt   = edge_ok ? (rev ? '0 : cnt_inc) : r_edge_cnt;
        n_rev_time   = rev ? r_tick_timer : r_rev_time;
        n_rev_ready  = r_rev_ready || rev;
        n_tick_timer = rev ? '0 : r_tick_timer + 1'b1;

        o_job.done = rev;
        if (!n_rev_ready) begin
            o_job.ticks  = '1;
            o_job.status = STAT_NONE;
        end else begin
            o_job.ticks = n_rev_time;
            if (n_rev_time == '0) begin
                o_job.status = STAT_ZERO;
            end else if (n_rev_time > r_stall_limit) begin
                o_job.status = STAT_STALL;
            end else begin
                o_job.status = STAT_VALID;
            end
        end
    end

    assign o_q_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= DEB_RESET;
            r_epr         <= EPR_RESET;
            r_stall_limit <= STALL_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE: r_debounce    <= i_cfg_data[DEB_W-1:0];
                CFG_EPR:      r_epr         <= i_cfg_data[EPR_W-1:0];
                CFG_STALL:    r_stall_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_timer <= '0;
            r_last_edge  <= '0;
            r_edge_cnt   <= '0;
            r_rev_time   <= '0;
            r_rev_ready  <= 1'b0;
        end else if (accept) begin
            r_tick_timer <= n_tick_timer;
            r_last_edge  <= n_last_edge;
            r_edge_cnt   <= n_edge_cnt;
            r_rev_time   <= n_rev_time;
            r_rev_ready  <= n_rev_ready;
        end
    end

endmodule

// ===== hdl/epsm_queue.sv =====
module epsm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  epsm_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output epsm_pkg::t_job  o_job,
    output logic            o_empty
);
    import epsm_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/epsm_back.sv =====
module epsm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  epsm_pkg::t_job                i_q_job,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output epsm_pkg::t_job                o_job,
    output logic [epsm_pkg::DATA_W-1:0]   o_speed
);
    import epsm_pkg::*;

    t_bk_state         r_state, n_state;
    t_job              r_job;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_out_valid;
    t_job              r_out_job;
    logic [DATA_W-1:0] r_out_speed;

    logic              out_free;
    logic              start_div;
    logic              load_direct;
    logic              load_div;
    logic [DATA_W:0]   trial;
    logic              q_bit;
    logic [DATA_W-1:0] rem_next;

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        start_div   = 1'b0;
        load_direct = 1'b0;
        load_div    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_job.status == STAT_VALID) begin
                        o_q_pop   = 1'b1;
                        start_div = 1'b1;
                        n_state   = BK_DIV;
                    end else if (out_free) begin
                        o_q_pop     = 1'b1;
                        load_direct = 1'b1;
                    end
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_state = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (out_free) begin
                    load_div = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // restoring divide, one quotient bit per cycle, msb first
    always_comb begin
        trial    = {r_rem, SPEED_NUM_Q12[r_cnt]};
        q_bit    = (trial >= {1'b0, r_div});
        rem_next = q_bit ? DATA_W'(trial - {1'b0, r_div}) : trial[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (start_div) begin
                r_cnt <= CNT_W'(DATA_W - 1);
            end else if (r_state == BK_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_job <= i_q_job;
            r_div <= i_q_job.ticks;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_state == BK_DIV) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[DATA_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_direct || load_div) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_direct) begin
            r_out_job   <= i_q_job;
            r_out_speed <= '0;
        end else if (load_div) begin
            r_out_job   <= r_job;
            r_out_speed <= r_quo;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_job   = r_out_job;
    assign o_speed = r_out_speed;

    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_job.status != STAT_VALID) |-> r_out_speed == '0)
        else $error("speed nonzero without valid status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out_job) && $stable(r_out_speed))
        else $error("waiting result changed before pop");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) && (r_cnt == '0) |=> r_state == BK_WAIT)
        else $error("divide did not end after last step");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("queue popped while empty");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_direct || load_div) |-> out_free)
        else $error("output register overwritten");

endmodule
